@@ rtl/clnw_pkg.sv @@
// Shared types and constants of the character-LCD nibble writer.
`timescale 1ns / 1ps
package clnw_pkg;

  // Decimal digits printed for a number
  localparam int unsigned NUM_DIGITS = 4;

  // Field widths
  localparam int unsigned OP_W      = 2;
  localparam int unsigned VALUE_W   = 16;
  localparam int unsigned NIBBLE_W  = 4;
  localparam int unsigned LINE_W    = 6;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 8;

  // BCD result width and conversion length
  localparam int unsigned BCD_W     = 4 * NUM_DIGITS;
  localparam int unsigned CONV_CNT_W = $clog2(VALUE_W + 1);

  // Nibble transmit buffer: a number or a wrapped character, whichever is longer
  localparam int unsigned TX_NIBS = (2 * NUM_DIGITS > 4) ? 2 * NUM_DIGITS : 4;
  localparam int unsigned TX_W    = NIBBLE_W * TX_NIBS;
  localparam int unsigned TX_CNT_W = $clog2(TX_NIBS + 1);

  function automatic longint unsigned pow10(input int unsigned n);
    longint unsigned r;
    r = 1;
    for (int unsigned i = 0; i < n; i++) begin
      r = r * 10;
    end
    return r;
  endfunction

  // Largest printable number
  localparam longint unsigned NUM_LIMIT = pow10(NUM_DIGITS) - 1;

  // Reset values of the configuration registers, and the top column count
  localparam logic [LINE_W-1:0] LINE_LENGTH_RST = 6'd16;
  localparam logic [BYTE_W-1:0] SECOND_LINE_RST = 8'hC0;
  localparam logic [LINE_W-1:0] COL_MAX         = 6'd63;

  // High nibble of an ASCII decimal digit
  localparam logic [NIBBLE_W-1:0] ASCII_DIGIT_HI = 4'h3;

  // Register-select codes
  localparam logic RS_INSTR = 1'b0;
  localparam logic RS_DATA  = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_CMD       = 2'd0,
    OP_STR_FIRST = 2'd1,
    OP_STR_NEXT  = 2'd2,
    OP_NUMBER    = 2'd3
  } clnw_op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LINE_LENGTH = 2'd0,
    CFG_SECOND_LINE = 2'd1
  } clnw_cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CONV = 3'b010,
    ST_SEND = 3'b100
  } clnw_state_e;

endpackage

@@ rtl/clnw_chan_if.sv @@
// Valid/ready channel interfaces: input items, nibble transfers, configuration writes.
`timescale 1ns / 1ps
interface clnw_in_if;
  import clnw_pkg::*;
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    op;
  logic [VALUE_W-1:0] value;
  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);
endinterface

interface clnw_out_if;
  import clnw_pkg::*;
  logic                valid;
  logic                ready;
  logic                reg_select;
  logic [NIBBLE_W-1:0] nibble;
  logic                last;
  modport source (output valid, output reg_select, output nibble, output last, input ready);
  modport sink   (input valid, input reg_select, input nibble, input last, output ready);
endinterface

interface clnw_cfg_if;
  import clnw_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/clnw_bcd_conv.sv @@
// Bit-serial binary to BCD converter (shift and add three).
`timescale 1ns / 1ps
module clnw_bcd_conv (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [clnw_pkg::VALUE_W-1:0]  bin_i,
  output logic                          done_o,
  output logic [clnw_pkg::BCD_W-1:0]    bcd_o
);
  import clnw_pkg::*;

  logic [VALUE_W-1:0]    bin_q, bin_d;
  logic [BCD_W-1:0]      bcd_q, bcd_d;
  logic [CONV_CNT_W-1:0] cnt_q, cnt_d;
  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [BCD_W-1:0]      bcd_adj;

  // Add three to every digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
                                                    : bcd_q[4*i +: 4];
    end
  end

  always_comb begin
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      bin_d  = bin_i;
      bcd_d  = '0;
      cnt_d  = CONV_CNT_W'(VALUE_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      bcd_d = {bcd_adj[BCD_W-2:0], bin_q[VALUE_W-1]};
      bin_d = {bin_q[VALUE_W-2:0], 1'b0};
      cnt_d = cnt_q - CONV_CNT_W'(1);
      if (cnt_q == CONV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign done_o = done_q;
  assign bcd_o  = bcd_q;

endmodule

@@ rtl/char_lcd_nibble_writer.sv @@
// Top level of the character-LCD nibble writer.
//
// Channels: in_i takes one item per transaction (op, value); out_o delivers
// one nibble transfer per transaction (reg_select, nibble, last); cfg_i writes
// line_length (index 0) or second_line_command (index 1) and is always ready.
// Every byte leaves as two transfers, high nibble first; last marks the final
// transfer caused by an item.
// Throughput: one item is worked on at a time. A command or a character
// moves its nibbles into the output register one per cycle while out_o does
// not stall; the line-two wrap puts the two command nibbles ahead of them.
// A number first runs through the bit-serial BCD converter, one input bit per
// cycle, before its digits are loaded into the transmit shift register.
// Reset: line_length returns to 16, second_line_command to 0xC0, the column
// counter and the wrap flag clear, and nothing is pending on out_o.
// Stall: the output register holds its transfer while out_o.ready is low and
// the sequencer waits; the next item is taken as soon as the last nibble of
// the present one sits in the output register, even if not yet taken.
`timescale 1ns / 1ps
module char_lcd_nibble_writer (
  input  logic        clk_i,
  input  logic        rst_ni,
  clnw_in_if.sink     in_i,
  clnw_out_if.source  out_o,
  clnw_cfg_if.sink    cfg_i
);
  import clnw_pkg::*;

  // Configuration registers
  logic [LINE_W-1:0] line_len_q;
  logic [BYTE_W-1:0] second_line_q;

  // Column state of the current string
  logic [LINE_W-1:0] col_q, col_d;
  logic              wrap_q, wrap_d;

  // Sequencer and nibble transmit shift register
  clnw_state_e         state_q, state_d;
  logic [TX_W-1:0]     tx_q, tx_d;
  logic [TX_NIBS-1:0]  rs_q, rs_d;
  logic [TX_CNT_W-1:0] cnt_q, cnt_d;

  // Output register
  logic                out_vld_q, out_vld_d;
  logic                out_rs_q, out_rs_d;
  logic [NIBBLE_W-1:0] out_nib_q, out_nib_d;
  logic                out_last_q, out_last_d;

  // Number path
  logic                conv_start;
  logic                conv_done;
  logic [BCD_W-1:0]    conv_bcd;
  logic [VALUE_W-1:0]  num_sat;

  logic                in_accept;
  logic                out_load;
  clnw_op_e            op;
  logic [LINE_W-1:0]   col_eff;
  logic                wrap_eff;
  logic                need_wrap;

  assign op        = clnw_op_e'(in_i.op);
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_accept = in_i.valid && in_i.ready;

  // Clamp the number to what NUM_DIGITS can print
  assign num_sat = ({48'd0, in_i.value} > NUM_LIMIT) ? VALUE_W'(NUM_LIMIT) : in_i.value;
  assign conv_start = in_accept && (op == OP_NUMBER);

  clnw_bcd_conv u_bcd_conv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (conv_start),
    .bin_i   (num_sat),
    .done_o  (conv_done),
    .bcd_o   (conv_bcd)
  );

  // A first character restarts the string before the wrap check
  assign col_eff   = (op == OP_STR_FIRST) ? '0   : col_q;
  assign wrap_eff  = (op == OP_STR_FIRST) ? 1'b0 : wrap_q;
  assign need_wrap = (col_eff >= line_len_q) && !wrap_eff;

  // Move the next nibble into the output register when it is free or being taken
  assign out_load = (state_q == ST_SEND) && (!out_vld_q || out_o.ready);

  always_comb begin
    state_d = state_q;
    tx_d    = tx_q;
    rs_d    = rs_q;
    cnt_d   = cnt_q;
    col_d   = col_q;
    wrap_d  = wrap_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          tx_d = '0;
          rs_d = '0;
          case (op) inside
            OP_CMD: begin
              tx_d[TX_W-1 -: 8] = in_i.value[BYTE_W-1:0];
              rs_d[TX_NIBS-1 -: 2] = {RS_INSTR, RS_INSTR};
              cnt_d   = TX_CNT_W'(2);
              state_d = ST_SEND;
            end
            OP_STR_FIRST, OP_STR_NEXT: begin
              if (need_wrap) begin
                // Send the line-two command once, ahead of the character
                tx_d[TX_W-1 -: 16]   = {second_line_q, in_i.value[BYTE_W-1:0]};
                rs_d[TX_NIBS-1 -: 4] = {RS_INSTR, RS_INSTR, RS_DATA, RS_DATA};
                cnt_d  = TX_CNT_W'(4);
                wrap_d = 1'b1;
              end else begin
                tx_d[TX_W-1 -: 8]    = in_i.value[BYTE_W-1:0];
                rs_d[TX_NIBS-1 -: 2] = {RS_DATA, RS_DATA};
                cnt_d  = TX_CNT_W'(2);
                wrap_d = wrap_eff;
              end
              col_d   = (col_eff < COL_MAX) ? col_eff + LINE_W'(1) : col_eff;
              state_d = ST_SEND;
            end
            default: begin
              // Number: wait for the converter
              state_d = ST_CONV;
            end
          endcase
        end
      end
      ST_CONV: begin
        if (conv_done) begin
          tx_d = '0;
          rs_d = '1;
          // Most significant digit first, each as ASCII
          for (int i = 0; i < NUM_DIGITS; i++) begin
            tx_d[TX_W-1-8*i -: 8] = {ASCII_DIGIT_HI, conv_bcd[4*(NUM_DIGITS-1-i) +: 4]};
          end
          cnt_d   = TX_CNT_W'(2 * NUM_DIGITS);
          state_d = ST_SEND;
        end
      end
      ST_SEND: begin
        if (out_load) begin
          tx_d  = {tx_q[TX_W-NIBBLE_W-1:0], {NIBBLE_W{1'b0}}};
          rs_d  = {rs_q[TX_NIBS-2:0], 1'b0};
          cnt_d = cnt_q - TX_CNT_W'(1);
          if (cnt_q == TX_CNT_W'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output register: hold while stalled, drop once taken
  always_comb begin
    out_vld_d  = out_vld_q;
    out_rs_d   = out_rs_q;
    out_nib_d  = out_nib_q;
    out_last_d = out_last_q;
    if (out_load) begin
      out_vld_d  = 1'b1;
      out_rs_d   = rs_q[TX_NIBS-1];
      out_nib_d  = tx_q[TX_W-1 -: NIBBLE_W];
      out_last_d = (cnt_q == TX_CNT_W'(1));
    end else if (out_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      cnt_q         <= '0;
      col_q         <= '0;
      wrap_q        <= 1'b0;
      out_vld_q     <= 1'b0;
      line_len_q    <= LINE_LENGTH_RST;
      second_line_q <= SECOND_LINE_RST;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      col_q     <= col_d;
      wrap_q    <= wrap_d;
      out_vld_q <= out_vld_d;
      if (cfg_i.valid && cfg_i.ready) begin
        unique case (clnw_cfg_idx_e'(cfg_i.index))
          CFG_LINE_LENGTH: line_len_q    <= cfg_i.data[LINE_W-1:0];
          CFG_SECOND_LINE: second_line_q <= cfg_i.data[BYTE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    tx_q       <= tx_d;
    rs_q       <= rs_d;
    out_rs_q   <= out_rs_d;
    out_nib_q  <= out_nib_d;
    out_last_q <= out_last_d;
  end

  assign cfg_i.ready      = 1'b1;
  assign out_o.valid      = out_vld_q;
  assign out_o.reg_select = out_rs_q;
  assign out_o.nibble     = out_nib_q;
  assign out_o.last       = out_last_q;

endmodule

@@ rtl/clnw_checker.sv @@
// Port-level checks of the character-LCD nibble writer, bound to the top level.
`timescale 1ns / 1ps
module clnw_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_i,
  input logic                           out_valid_i,
  input logic                           out_ready_i,
  input logic                           out_reg_select_i,
  input logic [clnw_pkg::NIBBLE_W-1:0]  out_nibble_i,
  input logic                           out_last_i,
  input logic                           cfg_valid_i,
  input logic                           cfg_ready_i
);
  import clnw_pkg::*;

  // Hold a stalled transfer unchanged
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(out_reg_select_i) && $stable(out_nibble_i) &&
       $stable(out_last_i)))
    else $error("stalled nibble transfer changed");

  // One item at a time: no second input transaction right after one
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("input taken while an item is in progress");

  // While a non-final transfer is shown the item is unfinished
  a_not_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_last_i) |-> !in_ready_i)
    else $error("input ready before the final transfer of an item");

  // Configuration writes are never stalled
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_i)
    else $error("configuration write stalled");

endmodule

bind char_lcd_nibble_writer clnw_checker u_clnw_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .out_reg_select_i (out_o.reg_select),
  .out_nibble_i     (out_o.nibble),
  .out_last_i       (out_o.last),
  .cfg_valid_i      (cfg_i.valid),
  .cfg_ready_i      (cfg_i.ready)
);

@@ test/tb_char_lcd_nibble_writer.sv @@
// Self-checking testbench of the character-LCD nibble writer.
`timescale 1ns / 1ps
module tb_char_lcd_nibble_writer;
  import clnw_pkg::*;

  // Values the registers take at reset, ASCII zero and the top column count
  localparam logic [LINE_W-1:0] DEFAULT_LINE_LEN  = 6'd16;
  localparam logic [BYTE_W-1:0] DEFAULT_LINE2_CMD = 8'hC0;
  localparam logic [BYTE_W-1:0] DIGIT_ZERO        = 8'h30;
  localparam logic [LINE_W-1:0] COLUMN_SAT        = 6'd63;

  // Cycles to let pass after the last transfer
  localparam int SETTLE_CYCLES  = 32;
  // Length of the long receiver hold-off
  localparam int HOLD_CYCLES    = 300;
  // Cycles without any transaction before the run is declared hung
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    logic                reg_select;
    logic [NIBBLE_W-1:0] nibble;
    logic                last;
  } nibble_xfer_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  clnw_in_if  in_if ();
  clnw_out_if out_if ();
  clnw_cfg_if cfg_if ();

  char_lcd_nibble_writer DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // Shadow of the block: registers and column state
  logic [LINE_W-1:0] line_len_q;
  logic [BYTE_W-1:0] line2_cmd_q;
  logic [LINE_W-1:0] column_q;
  logic              wrapped_q;

  // Nibble transfers still owed by the block, oldest first
  nibble_xfer_t pending_nibbles[$];

  int  items_sent     = 0;
  int  results_seen   = 0;
  int  reg_writes     = 0;
  int  mismatch_count = 0;
  int  idle_cycles    = 0;

  // Idling controls shared between the stimulus and the ready driver
  bit  gaps_on  = 1'b1;
  bit  stall_on = 1'b1;
  bit  hold_req = 1'b0;

  // Clock: 10 ns period
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ------------------------------------------------------------------
  // Prediction
  // ------------------------------------------------------------------

  // Queue the two nibble transfers of one byte, high nibble first; mark the
  // low nibble as last when this byte closes the item.
  function automatic void queue_byte(logic rs, logic [BYTE_W-1:0] b, bit closes);
    nibble_xfer_t x;
    x.reg_select = rs;
    x.nibble     = b[7:4];
    x.last       = 1'b0;
    pending_nibbles.push_back(x);
    x.nibble     = b[3:0];
    x.last       = closes;
    pending_nibbles.push_back(x);
  endfunction

  // Work out every nibble transfer that one accepted item causes and
  // advance the column state as the block does.
  function automatic void predict_transfers(clnw_op_e op, logic [VALUE_W-1:0] value);
    int unsigned num;
    int unsigned div;
    int unsigned digit;
    case (op) inside
      OP_CMD: begin
        queue_byte(RS_INSTR, value[7:0], 1'b1);
      end
      OP_STR_FIRST, OP_STR_NEXT: begin
        if (op == OP_STR_FIRST) begin
          column_q  = '0;
          wrapped_q = 1'b0;
        end
        // Line full: move to line two once per string
        if (column_q >= line_len_q && !wrapped_q) begin
          queue_byte(RS_INSTR, line2_cmd_q, 1'b0);
          wrapped_q = 1'b1;
        end
        queue_byte(RS_DATA, value[7:0], 1'b1);
        if (column_q != COLUMN_SAT) begin
          column_q = column_q + 1'b1;
        end
      end
      default: begin
        div = 1;
        for (int i = 1; i < NUM_DIGITS; i++) begin
          div = div * 10;
        end
        num = value;
        if (num > div * 10 - 1) begin
          num = div * 10 - 1;
        end
        for (int i = 0; i < NUM_DIGITS; i++) begin
          digit = num / div;
          num   = num - digit * div;
          queue_byte(RS_DATA, DIGIT_ZERO + BYTE_W'(digit), i == NUM_DIGITS - 1);
          div   = (div > 1) ? div / 10 : 1;
        end
      end
    endcase
  endfunction

  // ------------------------------------------------------------------
  // Random helpers
  // ------------------------------------------------------------------

  // Idle gap before an item: mostly none or short, now and then long
  function automatic int pick_gap(bit enable);
    int r;
    if (!enable) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [VALUE_W-1:0] rand_value();
    return VALUE_W'($urandom());
  endfunction

  // Numbers: mostly printable, some above the limit, some at the edges
  function automatic logic [VALUE_W-1:0] rand_number();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return VALUE_W'($urandom_range(0, 9999));
    if (r < 80) return rand_value();
    case ($urandom_range(0, 3))
      0:       return 16'd0;
      1:       return 16'd9999;
      2:       return 16'd10000;
      default: return 16'hFFFF;
    endcase
  endfunction

  // ------------------------------------------------------------------
  // Channel drivers
  // ------------------------------------------------------------------

  // Offer one item, hold it until the transaction, then predict its output.
  // Valid stays high on return so that a following item can go back to back.
  task automatic send_item(input clnw_op_e op, input logic [VALUE_W-1:0] value);
    int gap;
    gap = pick_gap(gaps_on);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.op    <= op;
    in_if.value <= value;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    predict_transfers(op, value);
    items_sent++;
  endtask

  // Drop valid and wait until the block owes nothing, then let it settle
  task automatic drain_results();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_nibbles.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // One register write; call only while the block is idle
  task automatic write_reg(input clnw_cfg_idx_e idx, input logic [CFG_DAT_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    cfg_if.valid <= 1'b0;
    case (idx)
      CFG_LINE_LENGTH: line_len_q  = data[LINE_W-1:0];
      CFG_SECOND_LINE: line2_cmd_q = data;
      default: ;
    endcase
    reg_writes++;
    @(posedge clk_i);
  endtask

  task automatic configure(input logic [CFG_DAT_W-1:0] len_data,
                           input logic [CFG_DAT_W-1:0] cmd_data);
    drain_results();
    write_reg(CFG_LINE_LENGTH, len_data);
    write_reg(CFG_SECOND_LINE, cmd_data);
  endtask

  // ------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------

  // Command bytes: all zeros, all ones, and upper value bits set (ignored)
  task automatic test_command_bytes();
    send_item(OP_CMD, 16'h0000);
    send_item(OP_CMD, 16'h00FF);
    send_item(OP_CMD, 16'hFF5A);
  endtask

  // Numbers at zero, at the limit, just above it, at full scale and two in range
  task automatic test_number_extremes();
    send_item(OP_NUMBER, 16'd0);
    send_item(OP_NUMBER, 16'd9999);
    send_item(OP_NUMBER, 16'd10000);
    send_item(OP_NUMBER, 16'hFFFF);
    send_item(OP_NUMBER, 16'd1234);
    send_item(OP_NUMBER, 16'd7);
  endtask

  // Short line: one wrap per string, and a next char with no first char
  // carries on from the present column
  task automatic test_string_wrap();
    configure(8'd3, 8'h80);
    send_item(OP_STR_FIRST, 16'h0041);
    send_item(OP_STR_NEXT,  16'h0042);
    send_item(OP_STR_NEXT,  16'h0043);
    send_item(OP_STR_NEXT,  16'hFF44);
    send_item(OP_STR_NEXT,  16'h0045);
    drain_results();
    send_item(OP_STR_NEXT,  16'h0046);
  endtask

  // Zero line length wraps before the first char; a command or a number
  // inside a string leaves the column state alone
  task automatic test_zero_line_length();
    configure(8'd0, 8'hFF);
    send_item(OP_STR_FIRST, 16'h00FF);
    send_item(OP_CMD,       16'h0001);
    send_item(OP_NUMBER,    16'd42);
    send_item(OP_STR_NEXT,  16'h0000);
  endtask

  // Mostly well-formed strings, with commands, numbers and some noise
  task automatic run_random_phase(input int n_items);
    int sent;
    int r;
    int len;
    gaps_on  = ($urandom_range(0, 3) != 0);
    stall_on = ($urandom_range(0, 3) != 0);
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        len = $urandom_range(1, int'(line_len_q) + 4);
        send_item(OP_STR_FIRST, rand_value());
        sent++;
        for (int k = 1; k < len && sent < n_items; k++) begin
          send_item(OP_STR_NEXT, rand_value());
          sent++;
        end
      end else if (r < 70) begin
        send_item(OP_CMD, rand_value());
        sent++;
      end else if (r < 85) begin
        send_item(OP_NUMBER, rand_number());
        sent++;
      end else if (r < 95) begin
        send_item(OP_STR_NEXT, rand_value());
        sent++;
      end else begin
        send_item(clnw_op_e'($urandom_range(0, 3)), rand_value());
        sent++;
      end
    end
    gaps_on  = 1'b1;
    stall_on = 1'b1;
  endtask

  // Random traffic at the reset settings, before any register is written
  task automatic test_reset_config_strings();
    run_random_phase(40);
  endtask

  // Random traffic over several settings, extremes among them
  task automatic test_random_traffic();
    configure(8'd1, 8'h00);
    run_random_phase(50);
    configure(8'd40, 8'hFF);
    run_random_phase(50);
    configure(8'd0, CFG_DAT_W'($urandom()));
    run_random_phase(50);
    configure(8'hFF, CFG_DAT_W'($urandom()));
    run_random_phase(50);
    configure(8'hC5, 8'h80);
    run_random_phase(50);
    configure(CFG_DAT_W'($urandom_range(1, 40)), CFG_DAT_W'($urandom()));
    run_random_phase(50);
    configure(CFG_DAT_W'($urandom_range(2, 12)), CFG_DAT_W'($urandom()));
    run_random_phase(50);
  endtask

  // Receiver holds off for a long stretch while items keep coming back to
  // back, so the block fills up and stalls its input
  task automatic test_receiver_holdoff();
    drain_results();
    gaps_on  = 1'b0;
    hold_req = 1'b1;
    for (int k = 0; k < 24; k++) begin
      send_item(clnw_op_e'($urandom_range(0, 3)), rand_value());
    end
    gaps_on  = 1'b1;
  endtask

  // One string longer than the column counter can count
  task automatic test_column_saturation();
    configure(8'd63, 8'hC0);
    send_item(OP_STR_FIRST, rand_value());
    for (int k = 1; k < 70; k++) begin
      send_item(OP_STR_NEXT, rand_value());
    end
  endtask

  // ------------------------------------------------------------------
  // Output ready: random stretches, plus the long hold-off on request
  // ------------------------------------------------------------------
  initial begin : out_ready_driver
    int run_left;
    int hold_left;
    bit level;
    out_if.ready = 1'b0;
    run_left     = 0;
    hold_left    = 0;
    level        = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        if (run_left == 0) begin
          if (!stall_on || $urandom_range(0, 99) < 60) begin
            level    = 1'b1;
            run_left = $urandom_range(1, 12);
          end else begin
            level    = 1'b0;
            run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                   : $urandom_range(1, 3);
          end
        end
        run_left--;
        out_if.ready <= level;
      end
    end
  end

  // ------------------------------------------------------------------
  // Checker: compare each transaction on out with the oldest expectation
  // ------------------------------------------------------------------
  always @(posedge clk_i) begin : transfer_checker
    nibble_xfer_t want;
    if (rst_ni === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      results_seen++;
      if (pending_nibbles.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("%0t: unexpected transfer rs=%b nibble=%h last=%b", $realtime,
                   out_if.reg_select, out_if.nibble, out_if.last);
        end
      end else begin
        want = pending_nibbles.pop_front();
        if (out_if.reg_select !== want.reg_select || out_if.nibble !== want.nibble ||
            out_if.last !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display({"%0t: mismatch expected rs=%b nibble=%h last=%b, ",
                      "got rs=%b nibble=%h last=%b"},
                     $realtime, want.reg_select, want.nibble, want.last,
                     out_if.reg_select, out_if.nibble, out_if.last);
          end
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // Watchdog: count cycles in which no channel completes a transaction
  // ------------------------------------------------------------------
  always @(posedge clk_i) begin : hang_watchdog
    if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
        (out_if.valid === 1'b1 && out_if.ready === 1'b1) ||
        (cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d transfers still owed", $realtime,
               idle_cycles, pending_nibbles.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ------------------------------------------------------------------
  // Sequence of tests
  // ------------------------------------------------------------------
  initial begin
    // Hold every input at a known value from time zero
    in_if.valid  = 1'b0;
    in_if.op     = OP_CMD;
    in_if.value  = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_LINE_LENGTH;
    cfg_if.data  = '0;
    rst_ni       = 1'b0;

    line_len_q  = DEFAULT_LINE_LEN;
    line2_cmd_q = DEFAULT_LINE2_CMD;
    column_q    = '0;
    wrapped_q   = 1'b0;

    // Hold reset, then release it at a clock edge
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_command_bytes();
    test_number_extremes();
    test_reset_config_strings();
    test_string_wrap();
    test_zero_line_length();
    test_random_traffic();
    test_receiver_holdoff();
    test_column_saturation();

    // Wait out everything still owed, then report
    drain_results();
    $display("Sent %0d items (commands, strings across line lengths 0 to 63, numbers)",
             items_sent);
    $display("Checked %0d nibble transfers after %0d register writes, %0d mismatches",
             results_seen, reg_writes, mismatch_count);
    if (mismatch_count == 0 && pending_nibbles.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
